FILE: hw/rtl/sip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sip_pkg: shared types and constants for the segment intersection block
// Width of the Q-format result fields and the layout of one result word.
// ----------------------------------------------------------------------------
package sip_pkg;

   localparam int OUT_BITS = 32;

   typedef struct packed {
      logic                crosses;
      logic [OUT_BITS-1:0] cross_x;
      logic [OUT_BITS-1:0] cross_y;
   } word_type;

endpackage
`default_nettype wire

FILE: hw/rtl/segment_intersection_point.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_intersection_point: proper crossing test and crossing point
// Four cross-product sign tests decide whether segments A and B properly
// cross; on a hit the point A.start + t * dA is produced in signed Q.FRAC_BITS.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | word
//  req_    | in  | req_valid/req_stall  | eight signed endpoint coordinates
//  rsp_    | out | rsp_valid/rsp_stall  | crosses, cross_x, cross_y
//
//  One word enters per cycle while req_stall is low; an accepted word passes
//  the front stages, the divider (one quotient digit per stage) and the
//  output queue before it shows on rsp_.
//  Reset clears the valid bits and the two-slot output queue.
//  rsp_stall fills the output queue; req_stall rises only with both slots full,
//  and the whole pipeline holds while it is high.
// ----------------------------------------------------------------------------
module segment_intersection_point #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [COORD_BITS-1:0]        req_a_start_x,
   input  wire logic signed [COORD_BITS-1:0]        req_a_start_y,
   input  wire logic signed [COORD_BITS-1:0]        req_a_end_x,
   input  wire logic signed [COORD_BITS-1:0]        req_a_end_y,
   input  wire logic signed [COORD_BITS-1:0]        req_b_start_x,
   input  wire logic signed [COORD_BITS-1:0]        req_b_start_y,
   input  wire logic signed [COORD_BITS-1:0]        req_b_end_x,
   input  wire logic signed [COORD_BITS-1:0]        req_b_end_y,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_crosses,
   output logic signed [sip_pkg::OUT_BITS-1:0]      rsp_cross_x,
   output logic signed [sip_pkg::OUT_BITS-1:0]      rsp_cross_y
);
   import sip_pkg::*;

   localparam int DW      = COORD_BITS + 1;
   localparam int PW      = 2 * DW;
   localparam int MW      = 2 * COORD_BITS + 1;
   localparam int DIV_LAT = COORD_BITS + FRAC_BITS + 2;
   localparam logic [1:0] FULL_COUNT = 2'd2;

   function automatic logic signed [DW-1:0] diff(input logic [COORD_BITS-1:0] p,
                                                 input logic [COORD_BITS-1:0] q);
      return {p[COORD_BITS-1], p} - {q[COORD_BITS-1], q};
   endfunction

   logic en;

   // stage 1: edge and offset vectors
   logic                         s1_v_ff;
   logic signed [DW-1:0]         s1_dax_ff, s1_day_ff, s1_dbx_ff, s1_dby_ff;
   logic signed [DW-1:0]         s1_ex_ff, s1_ey_ff, s1_fx_ff, s1_fy_ff;
   logic signed [DW-1:0]         s1_gx_ff, s1_gy_ff, s1_hx_ff, s1_hy_ff;
   logic signed [COORD_BITS-1:0] s1_ax_ff, s1_ay_ff;

   // stage 2: partial products
   logic                         s2_v_ff;
   logic signed [PW-1:0]         s2_p1a_ff, s2_p1b_ff, s2_p2a_ff, s2_p2b_ff;
   logic signed [PW-1:0]         s2_p3a_ff, s2_p3b_ff, s2_p4a_ff, s2_p4b_ff;
   logic signed [PW-1:0]         s2_p5a_ff, s2_p5b_ff;
   logic signed [DW-1:0]         s2_dax_ff, s2_day_ff;
   logic signed [COORD_BITS-1:0] s2_ax_ff, s2_ay_ff;

   // stage 3: cross products
   logic                         s3_v_ff;
   logic signed [PW-1:0]         s3_c1_ff, s3_c2_ff, s3_c3_ff, s3_c4_ff, s3_den_ff;
   logic signed [DW-1:0]         s3_dax_ff, s3_day_ff;
   logic signed [COORD_BITS-1:0] s3_ax_ff, s3_ay_ff;

   // stage 4: hit decision and divider operands
   logic                         s4_v_ff;
   logic                         s4_hit_ff;
   logic [MW-1:0]                s4_num_ff, s4_den_ff;
   logic [COORD_BITS-1:0]        s4_magx_ff, s4_magy_ff;
   logic                         s4_negx_ff, s4_negy_ff;
   logic [OUT_BITS-1:0]          s4_basex_ff, s4_basey_ff;

   logic [PW-1:0]                neg_num, neg_den;
   logic [DW-1:0]                neg_dax, neg_day;
   logic                         hit_in;
   logic [MW-1:0]                num_in, den_in;
   logic [COORD_BITS-1:0]        magx_in, magy_in;

   logic [DIV_LAT-1:0]           line_v_ff;
   logic [DIV_LAT-1:0]           line_hit_ff;
   logic [OUT_BITS-1:0]          res_x, res_y;

   word_type                     fifo_ff [2];
   word_type                     push_word;
   word_type                     head;
   logic                         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]                   count_ff;
   logic                         push, pop;

   assign en        = (count_ff != FULL_COUNT);
   assign req_stall = ~en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         s3_v_ff   <= 1'b0;
         s4_v_ff   <= 1'b0;
         line_v_ff <= '0;
      end else if (en) begin
         s1_v_ff   <= req_valid;
         s2_v_ff   <= s1_v_ff;
         s3_v_ff   <= s2_v_ff;
         s4_v_ff   <= s3_v_ff;
         line_v_ff <= {line_v_ff[DIV_LAT-2:0], s4_v_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_dax_ff <= diff(req_a_end_x, req_a_start_x);
         s1_day_ff <= diff(req_a_end_y, req_a_start_y);
         s1_dbx_ff <= diff(req_b_end_x, req_b_start_x);
         s1_dby_ff <= diff(req_b_end_y, req_b_start_y);
         s1_ex_ff  <= diff(req_b_start_x, req_a_start_x);
         s1_ey_ff  <= diff(req_b_start_y, req_a_start_y);
         s1_fx_ff  <= diff(req_b_end_x, req_a_start_x);
         s1_fy_ff  <= diff(req_b_end_y, req_a_start_y);
         s1_gx_ff  <= diff(req_a_start_x, req_b_start_x);
         s1_gy_ff  <= diff(req_a_start_y, req_b_start_y);
         s1_hx_ff  <= diff(req_a_end_x, req_b_start_x);
         s1_hy_ff  <= diff(req_a_end_y, req_b_start_y);
         s1_ax_ff  <= req_a_start_x;
         s1_ay_ff  <= req_a_start_y;

         s2_p1a_ff <= PW'(s1_dax_ff) * PW'(s1_ey_ff);
         s2_p1b_ff <= PW'(s1_day_ff) * PW'(s1_ex_ff);
         s2_p2a_ff <= PW'(s1_dax_ff) * PW'(s1_fy_ff);
         s2_p2b_ff <= PW'(s1_day_ff) * PW'(s1_fx_ff);
         s2_p3a_ff <= PW'(s1_dbx_ff) * PW'(s1_gy_ff);
         s2_p3b_ff <= PW'(s1_dby_ff) * PW'(s1_gx_ff);
         s2_p4a_ff <= PW'(s1_dbx_ff) * PW'(s1_hy_ff);
         s2_p4b_ff <= PW'(s1_dby_ff) * PW'(s1_hx_ff);
         s2_p5a_ff <= PW'(s1_dax_ff) * PW'(s1_dby_ff);
         s2_p5b_ff <= PW'(s1_day_ff) * PW'(s1_dbx_ff);
         s2_dax_ff <= s1_dax_ff;
         s2_day_ff <= s1_day_ff;
         s2_ax_ff  <= s1_ax_ff;
         s2_ay_ff  <= s1_ay_ff;

         s3_c1_ff  <= s2_p1a_ff - s2_p1b_ff;
         s3_c2_ff  <= s2_p2a_ff - s2_p2b_ff;
         s3_c3_ff  <= s2_p3a_ff - s2_p3b_ff;
         s3_c4_ff  <= s2_p4a_ff - s2_p4b_ff;
         s3_den_ff <= s2_p5a_ff - s2_p5b_ff;
         s3_dax_ff <= s2_dax_ff;
         s3_day_ff <= s2_day_ff;
         s3_ax_ff  <= s2_ax_ff;
         s3_ay_ff  <= s2_ay_ff;
      end
   end

   always_comb begin
      neg_num = -s3_c3_ff;
      neg_den = -s3_den_ff;
      neg_dax = -s3_dax_ff;
      neg_day = -s3_day_ff;
      hit_in  = (s3_c1_ff != '0) && (s3_c2_ff != '0)
                && (s3_c1_ff[PW-1] != s3_c2_ff[PW-1])
                && (s3_c3_ff != '0) && (s3_c4_ff != '0)
                && (s3_c3_ff[PW-1] != s3_c4_ff[PW-1])
                && (s3_den_ff != '0);
      num_in  = s3_c3_ff[PW-1] ? neg_num[MW-1:0] : s3_c3_ff[MW-1:0];
      den_in  = s3_den_ff[PW-1] ? neg_den[MW-1:0] : s3_den_ff[MW-1:0];
      magx_in = s3_dax_ff[DW-1] ? neg_dax[COORD_BITS-1:0] : s3_dax_ff[COORD_BITS-1:0];
      magy_in = s3_day_ff[DW-1] ? neg_day[COORD_BITS-1:0] : s3_day_ff[COORD_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_hit_ff   <= hit_in;
         s4_num_ff   <= num_in;
         s4_den_ff   <= den_in;
         s4_magx_ff  <= magx_in;
         s4_magy_ff  <= magy_in;
         s4_negx_ff  <= s3_c3_ff[PW-1] ^ s3_den_ff[PW-1] ^ s3_dax_ff[DW-1];
         s4_negy_ff  <= s3_c3_ff[PW-1] ^ s3_den_ff[PW-1] ^ s3_day_ff[DW-1];
         s4_basex_ff <= {{(OUT_BITS-COORD_BITS){s3_ax_ff[COORD_BITS-1]}}, s3_ax_ff}
                        << FRAC_BITS;
         s4_basey_ff <= {{(OUT_BITS-COORD_BITS){s3_ay_ff[COORD_BITS-1]}}, s3_ay_ff}
                        << FRAC_BITS;
         line_hit_ff <= {line_hit_ff[DIV_LAT-2:0], s4_hit_ff};
      end
   end

   sip_div #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div_x (
      .clock  (clock),
      .en     (en),
      .num    (s4_num_ff),
      .den    (s4_den_ff),
      .mag    (s4_magx_ff),
      .neg    (s4_negx_ff),
      .base   (s4_basex_ff),
      .result (res_x)
   );

   sip_div #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div_y (
      .clock  (clock),
      .en     (en),
      .num    (s4_num_ff),
      .den    (s4_den_ff),
      .mag    (s4_magy_ff),
      .neg    (s4_negy_ff),
      .base   (s4_basey_ff),
      .result (res_y)
   );

   // output queue: two words
   assign push = en & line_v_ff[DIV_LAT-1];
   assign pop  = rsp_valid & ~rsp_stall;

   always_comb begin
      push_word.crosses = line_hit_ff[DIV_LAT-1];
      push_word.cross_x = line_hit_ff[DIV_LAT-1] ? res_x : '0;
      push_word.cross_y = line_hit_ff[DIV_LAT-1] ? res_y : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign head        = fifo_ff[rd_ptr_ff];
   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_crosses = head.crosses;
   assign rsp_cross_x = head.cross_x;
   assign rsp_cross_y = head.cross_y;

endmodule
`default_nettype wire

FILE: hw/rtl/sip_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sip_div: pipelined scaled divider for one crossing coordinate
// Computes base +/- floor(num * mag * 2^FRAC_BITS / den) modulo 2^OUT_BITS,
// one multiplier bit per stage (zero in the last FRAC_BITS) with a radix-2
// digit in {0,1,2}, then a carry-propagate stage and a signed offset stage.
// ----------------------------------------------------------------------------
module sip_div #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [2*COORD_BITS:0]         num,
   input  wire logic [2*COORD_BITS:0]         den,
   input  wire logic [COORD_BITS-1:0]         mag,
   input  wire logic                          neg,
   input  wire logic [sip_pkg::OUT_BITS-1:0]  base,
   output logic      [sip_pkg::OUT_BITS-1:0]  result
);
   import sip_pkg::*;

   localparam int MW    = 2 * COORD_BITS + 1;
   localparam int STEPS = COORD_BITS + FRAC_BITS;

   logic [MW-1:0]         r_ff    [STEPS];
   logic [MW-1:0]         num_ff  [STEPS];
   logic [MW-1:0]         den_ff  [STEPS];
   logic [COORD_BITS-1:0] mag_ff  [STEPS];
   logic                  neg_ff  [STEPS];
   logic [OUT_BITS-1:0]   base_ff [STEPS];
   logic [OUT_BITS-1:0]   qa_ff   [STEPS];
   logic [OUT_BITS-1:0]   qb_ff   [STEPS];

   logic [OUT_BITS-1:0]   q_ff;
   logic                  qneg_ff;
   logic [OUT_BITS-1:0]   qbase_ff;
   logic [OUT_BITS-1:0]   result_ff;

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [MW-1:0]         r_cur;
      logic [MW-1:0]         num_cur;
      logic [MW-1:0]         den_cur;
      logic [COORD_BITS-1:0] mag_cur;
      logic                  neg_cur;
      logic [OUT_BITS-1:0]   base_cur;
      logic [OUT_BITS-1:0]   qa_cur;
      logic [OUT_BITS-1:0]   qb_cur;
      logic                  bit_cur;
      logic [MW+1:0]         sum;
      logic [MW+1:0]         den1;
      logic [MW+1:0]         den2;
      logic                  ge1;
      logic                  ge2;
      logic [MW+1:0]         r_in;

      if (k == 0) begin : g_head
         assign r_cur    = '0;
         assign num_cur  = num;
         assign den_cur  = den;
         assign mag_cur  = mag;
         assign neg_cur  = neg;
         assign base_cur = base;
         assign qa_cur   = '0;
         assign qb_cur   = '0;
      end else begin : g_body
         assign r_cur    = r_ff[k-1];
         assign num_cur  = num_ff[k-1];
         assign den_cur  = den_ff[k-1];
         assign mag_cur  = mag_ff[k-1];
         assign neg_cur  = neg_ff[k-1];
         assign base_cur = base_ff[k-1];
         assign qa_cur   = qa_ff[k-1];
         assign qb_cur   = qb_ff[k-1];
      end

      if (k < COORD_BITS) begin : g_mul
         assign bit_cur = mag_cur[COORD_BITS-1-k];
      end else begin : g_frac
         assign bit_cur = 1'b0;
      end

      always_comb begin
         sum  = {1'b0, r_cur, 1'b0} + (bit_cur ? {2'b00, num_cur} : {(MW+2){1'b0}});
         den1 = {2'b00, den_cur};
         den2 = {1'b0, den_cur, 1'b0};
         ge2  = (sum >= den2);
         ge1  = (sum >= den1);
         priority if (ge2) begin
            r_in = sum - den2;
         end else if (ge1) begin
            r_in = sum - den1;
         end else begin
            r_in = sum;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k]    <= r_in[MW-1:0];
            num_ff[k]  <= num_cur;
            den_ff[k]  <= den_cur;
            mag_ff[k]  <= mag_cur;
            neg_ff[k]  <= neg_cur;
            base_ff[k] <= base_cur;
            qa_ff[k]   <= {qa_cur[OUT_BITS-2:0], ge1 & ~ge2};
            qb_ff[k]   <= {qb_cur[OUT_BITS-2:0], ge2};
         end
      end
   end

   // fold the redundant quotient, then apply sign and origin
   always_ff @(posedge clock) begin
      if (en) begin
         q_ff      <= qa_ff[STEPS-1] + {qb_ff[STEPS-1][OUT_BITS-2:0], 1'b0};
         qneg_ff   <= neg_ff[STEPS-1];
         qbase_ff  <= base_ff[STEPS-1];
         result_ff <= qneg_ff ? (qbase_ff - q_ff) : (qbase_ff + q_ff);
      end
   end

   assign result = result_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/sip_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sip_checker: port-level checks for segment_intersection_point
// Watches the result channel and input stall over time; bound to the top.
// ----------------------------------------------------------------------------
module sip_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_stall,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic                           rsp_crosses,
   input wire logic [sip_pkg::OUT_BITS-1:0]   rsp_cross_x,
   input wire logic [sip_pkg::OUT_BITS-1:0]   rsp_cross_y
);
   import sip_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_crosses)
                                 && $stable(rsp_cross_x) && $stable(rsp_cross_y))
      else $error("result word changed while stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_crosses |-> rsp_cross_x == '0 && rsp_cross_y == '0)
      else $error("point nonzero on a miss");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result waiting");

   a_stall_drain: assert property (@(posedge clock) disable iff (reset)
      req_stall && rsp_valid && !rsp_stall |=> !req_stall)
      else $error("input still stalled after a result was taken");

endmodule

bind segment_intersection_point sip_checker u_sip_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_crosses (rsp_crosses),
   .rsp_cross_x (rsp_cross_x),
   .rsp_cross_y (rsp_cross_y)
);
`default_nettype wire

FILE: tb/tb_segment_intersection_point.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_intersection_point: self-checking bench for segment crossing
// Drives segment pairs with random gaps and output stalls, predicts each
// crossing flag and Q16.16 point in a scoreboard, and checks every word in
// order.
// ----------------------------------------------------------------------------
module tb_segment_intersection_point;

   import sip_pkg::*;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int LATENCY    = COORD_BITS + FRAC_BITS + 6;
   localparam int N_RANDOM   = 1200;
   localparam int LIMIT      = 2000000;
   localparam int MAX_SHOWN  = 10;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] a_start_x;
      logic signed [COORD_BITS-1:0] a_start_y;
      logic signed [COORD_BITS-1:0] a_end_x;
      logic signed [COORD_BITS-1:0] a_end_y;
      logic signed [COORD_BITS-1:0] b_start_x;
      logic signed [COORD_BITS-1:0] b_start_y;
      logic signed [COORD_BITS-1:0] b_end_x;
      logic signed [COORD_BITS-1:0] b_end_y;
   } seg_pair_type;

   class crossing_scoreboard;
      word_type expected_words[$];
      int       errors;

      function automatic int sign_of(longint v);
         return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
      endfunction

      function automatic longint unsigned magnitude(longint v);
         return (v < 0) ? longint'(-v) : longint'(v);
      endfunction

      function automatic longint cross2(longint ux, longint uy, longint vx, longint vy);
         return ux * vy - uy * vx;
      endfunction

      // offset along one axis: num * d * 2^FRAC / den, truncated toward zero
      function automatic longint shift_along(longint num, longint den, longint d);
         logic [127:0] prod;
         logic [127:0] quot;
         longint       q;
         prod = 128'(magnitude(num)) * 128'(magnitude(d));
         prod = prod << FRAC_BITS;
         quot = prod / 128'(magnitude(den));
         q    = longint'(quot[63:0]);
         return (sign_of(num) * sign_of(d) * sign_of(den) < 0) ? -q : q;
      endfunction

      function automatic word_type crossing_point(seg_pair_type s);
         longint   ax1 = longint'($signed(s.a_start_x));
         longint   ay1 = longint'($signed(s.a_start_y));
         longint   ax2 = longint'($signed(s.a_end_x));
         longint   ay2 = longint'($signed(s.a_end_y));
         longint   bx1 = longint'($signed(s.b_start_x));
         longint   by1 = longint'($signed(s.b_start_y));
         longint   bx2 = longint'($signed(s.b_end_x));
         longint   by2 = longint'($signed(s.b_end_y));
         longint   dax, day, dbx, dby, c1, c2, c3, c4, den, px, py;
         bit       hit;
         word_type w;
         dax = ax2 - ax1;
         day = ay2 - ay1;
         dbx = bx2 - bx1;
         dby = by2 - by1;
         c1  = cross2(dax, day, bx1 - ax1, by1 - ay1);
         c2  = cross2(dax, day, bx2 - ax1, by2 - ay1);
         c3  = cross2(dbx, dby, ax1 - bx1, ay1 - by1);
         c4  = cross2(dbx, dby, ax2 - bx1, ay2 - by1);
         den = cross2(dax, day, dbx, dby);
         hit = (sign_of(c1) * sign_of(c2) < 0) && (sign_of(c3) * sign_of(c4) < 0)
               && (den != 0);
         w = '0;
         if (hit) begin
            px = ax1 * (longint'(1) << FRAC_BITS) + shift_along(c3, den, dax);
            py = ay1 * (longint'(1) << FRAC_BITS) + shift_along(c3, den, day);
            w.crosses = 1'b1;
            w.cross_x = px[OUT_BITS-1:0];
            w.cross_y = py[OUT_BITS-1:0];
         end
         return w;
      endfunction

      function automatic void flag(string msg);
         errors++;
         if (errors <= MAX_SHOWN) $display("mismatch: %s", msg);
      endfunction

      function automatic void note_pair(seg_pair_type s);
         expected_words.push_back(crossing_point(s));
      endfunction

      function automatic void check_word(word_type got);
         word_type want;
         if (expected_words.size() == 0) begin
            flag($sformatf("unexpected word crosses=%0b x=%h y=%h",
                           got.crosses, got.cross_x, got.cross_y));
            return;
         end
         want = expected_words.pop_front();
         if (got.crosses !== want.crosses)
            flag($sformatf("crosses expected %0b got %0b", want.crosses, got.crosses));
         if (got.cross_x !== want.cross_x)
            flag($sformatf("cross_x expected %h got %h", want.cross_x, got.cross_x));
         if (got.cross_y !== want.cross_y)
            flag($sformatf("cross_y expected %h got %h", want.cross_y, got.cross_y));
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   seg_pair_type                drive;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic                        rsp_crosses;
   logic signed [OUT_BITS-1:0]  rsp_cross_x;
   logic signed [OUT_BITS-1:0]  rsp_cross_y;

   crossing_scoreboard sb;
   int                 cycles;

   segment_intersection_point #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_a_start_x (drive.a_start_x),
      .req_a_start_y (drive.a_start_y),
      .req_a_end_x   (drive.a_end_x),
      .req_a_end_y   (drive.a_end_y),
      .req_b_start_x (drive.b_start_x),
      .req_b_start_y (drive.b_start_y),
      .req_b_end_x   (drive.b_end_x),
      .req_b_end_y   (drive.b_end_y),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_crosses   (rsp_crosses),
      .rsp_cross_x   (rsp_cross_x),
      .rsp_cross_y   (rsp_cross_y)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      word_type got;
      if (!reset && req_valid && !req_stall) sb.note_pair(drive);
      if (!reset && rsp_valid && !rsp_stall) begin
         got.crosses = rsp_crosses;
         got.cross_x = rsp_cross_x;
         got.cross_y = rsp_cross_y;
         sb.check_word(got);
      end
   end

   // mostly short, a few long
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   initial begin
      int run;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                            : 1 + idle_length();
         rsp_stall <= 1'b0;
         repeat (run) @(negedge clock);
         rsp_stall <= 1'b1;
         repeat (1 + idle_length()) @(negedge clock);
      end
   end

   task automatic send_pair(input seg_pair_type s, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      drive     <= s;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic seg_pair_type make_pair(int ax1, int ay1, int ax2, int ay2,
                                              int bx1, int by1, int bx2, int by2);
      seg_pair_type p;
      p.a_start_x = COORD_BITS'(ax1);
      p.a_start_y = COORD_BITS'(ay1);
      p.a_end_x   = COORD_BITS'(ax2);
      p.a_end_y   = COORD_BITS'(ay2);
      p.b_start_x = COORD_BITS'(bx1);
      p.b_start_y = COORD_BITS'(by1);
      p.b_end_x   = COORD_BITS'(bx2);
      p.b_end_y   = COORD_BITS'(by2);
      return p;
   endfunction

   function automatic int coord(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic int extreme_coord();
      case ($urandom_range(0, 5))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3: return -1;
         4: return 1;
         default: return coord(32767);
      endcase
   endfunction

   function automatic seg_pair_type random_pair();
      int kind, span, f, mx, my, lx, ly, vx, vy, i, j;
      int ax1, ay1, ax2, ay2;
      kind = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
         0: span = 8;
         1: span = 256;
         2: span = 4096;
         default: span = 32767;
      endcase
      ax1 = coord(span);
      ay1 = coord(span);
      ax2 = coord(span);
      ay2 = coord(span);
      if (kind <= 4) begin
         // place B across a point inside A
         f  = $urandom_range(1, 255);
         mx = ax1 + ((ax2 - ax1) * f) / 256;
         my = ay1 + ((ay2 - ay1) * f) / 256;
         lx = (32767 - (mx < 0 ? -mx : mx));
         ly = (32767 - (my < 0 ? -my : my));
         lx = (lx < span) ? lx : span;
         ly = (ly < span) ? ly : span;
         vx = coord(lx);
         vy = coord(ly);
         return make_pair(ax1, ay1, ax2, ay2, mx + vx, my + vy, mx - vx, my - vy);
      end
      if (kind <= 6)
         return make_pair(ax1, ay1, ax2, ay2, coord(span), coord(span),
                          coord(span), coord(span));
      if (kind == 7)
         return make_pair(coord(4), coord(4), coord(4), coord(4),
                          coord(4), coord(4), coord(4), coord(4));
      if (kind == 8) begin
         // B on the line of A
         ax1 = coord(8);
         ay1 = coord(8);
         ax2 = coord(8);
         ay2 = coord(8);
         i   = int'($urandom_range(0, 5)) - 2;
         j   = int'($urandom_range(0, 5)) - 2;
         return make_pair(ax1, ay1, ax2, ay2,
                          ax1 + i * (ax2 - ax1), ay1 + i * (ay2 - ay1),
                          ax1 + j * (ax2 - ax1), ay1 + j * (ay2 - ay1));
      end
      return make_pair(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
                       extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord());
   endfunction

   task automatic run_directed();
      send_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 0), 0);
      send_pair(make_pair(0, 0, 3, 1, 1, 2, 2, -1), 0);
      send_pair(make_pair(-7, -3, 5, 4, -6, 3, 4, -5), 1);
      send_pair(make_pair(0, 0, 10, 0, 10, 0, 10, 10), 0);
      send_pair(make_pair(0, 0, 10, 0, 5, 0, 5, 5), 0);
      send_pair(make_pair(0, 0, 10, 10, 5, 5, 0, 9), 2);
      send_pair(make_pair(0, 0, 10, 0, 5, 0, 15, 0), 0);
      send_pair(make_pair(0, 0, 2, 0, 5, 0, 9, 0), 0);
      send_pair(make_pair(0, 0, 10, 0, 0, 1, 10, 1), 0);
      send_pair(make_pair(3, 3, 3, 3, 0, 0, 5, 5), 0);
      send_pair(make_pair(4, -2, 4, -2, 4, -2, 4, -2), 3);
      send_pair(make_pair(100, 100, 200, 300, -500, -500, -400, -900), 0);
      send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768), 0);
      send_pair(make_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767), 0);
      send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768), 0);
      send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 0);
      send_pair(make_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767), 5);
      send_pair(make_pair(-32768, -32767, 32767, 32766, 0, 1, 1, -1), 0);
      send_pair(make_pair(0, -32768, 0, 32767, -32768, 0, 32767, 0), 0);
      send_pair(make_pair(21845, -21846, -21846, 21845, -21846, -21846, 21845, 21845), 0);
      send_pair(make_pair(-1, -1, -32768, 32767, 32767, -32768, -32768, -1), 0);
   endtask

   initial begin
      int gap;
      sb        = new();
      cycles    = 0;
      reset     = 1'b1;
      req_valid = 1'b0;
      drive     = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      run_directed();
      for (int n = 0; n < N_RANDOM; n++) begin
         gap = (((n / 100) % 4) == 2) ? 0 : idle_length();
         send_pair(random_pair(), gap);
      end
      req_valid <= 1'b0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (2 * LATENCY + 20) @(posedge clock);
      if (sb.errors == 0 && sb.expected_words.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
